// ===== sv/bmh_pkg.sv =====
// Shared types and constants for the bounded max-heap top-k block.
package bmh_pkg;

  localparam int FW = 9;
  localparam int KW = 32;
  localparam int IW = 32;
  localparam int MAX_FILL = (1 << FW) - 1;
  localparam logic [FW-1:0] BOUND_RST = 9'd256;
  localparam int IN_W = KW + IW;
  localparam int OUT_BITS = 2 + FW + KW + IW + 1;
  localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    STATUS_APPEND  = 2'd0,
    STATUS_REPLACE = 2'd1,
    STATUS_DROP    = 2'd2
  } kind_t;

  typedef struct packed {
    logic [KW-1:0] key;
    logic [IW-1:0] id;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic up_rd;
    logic up_cmp;
    logic dn_rd;
    logic dn_cmp;
    logic emit;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  pos_zero;
    logic  up_swap;
    logic  dn_move;
    logic  out_free;
  } sts_t;

endpackage

// ===== sv/bmh_ctrl.sv =====
// Sequencer for push, sift-up, sift-down and result hand-off.
module bmh_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bmh_pkg::sts_t  sts,
  output bmh_pkg::cmd_t  cmd
);
  import bmh_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_UP_RD  = 6'b000010,
    ST_UP_CMP = 6'b000100,
    ST_DN_RD  = 6'b001000,
    ST_DN_CMP = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (sts.kind)
            STATUS_APPEND:  state_next = ST_UP_RD;
            STATUS_REPLACE: state_next = ST_DN_RD;
            default:        state_next = ST_EMIT;
          endcase
        end
      end
      ST_UP_RD:  state_next = sts.pos_zero ? ST_EMIT : ST_UP_CMP;
      ST_UP_CMP: state_next = sts.up_swap ? ST_UP_RD : ST_EMIT;
      ST_DN_RD:  state_next = ST_DN_CMP;
      ST_DN_CMP: state_next = sts.dn_move ? ST_DN_RD : ST_EMIT;
      ST_EMIT:   state_next = sts.out_free ? ST_IDLE : ST_EMIT;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign in_ready   = (state == ST_IDLE);
  assign cmd.accept = (state == ST_IDLE) && in_valid;
  assign cmd.up_rd  = (state == ST_UP_RD);
  assign cmd.up_cmp = (state == ST_UP_CMP);
  assign cmd.dn_rd  = (state == ST_DN_RD);
  assign cmd.dn_cmp = (state == ST_DN_CMP);
  assign cmd.emit   = (state == ST_EMIT);

endmodule

// ===== sv/bmh_dp.sv =====
// Heap store, slot pointers, fill count, bound register and result register.
module bmh_dp #(
  parameter int CAPACITY = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic [bmh_pkg::FW-1:0]     cfg_data,
  input  logic [bmh_pkg::IN_W-1:0]   in_data,
  input  bmh_pkg::cmd_t              cmd,
  output bmh_pkg::sts_t              sts,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bmh_pkg::OUT_W-1:0]  out_data
);
  import bmh_pkg::*;

  localparam int DEPTH = (CAPACITY > MAX_FILL) ? MAX_FILL : CAPACITY;
  localparam int AW = $clog2(DEPTH);
  localparam int XW = (AW + 2 > FW) ? AW + 2 : FW;
  localparam logic [FW-1:0] CAP_LIM = FW'(DEPTH);

  entry_t mem [DEPTH];

  logic [FW-1:0] bound;
  logic [FW-1:0] count;
  logic [AW-1:0] pos, par, lft, rgt;
  logic          lok, rok;
  entry_t        new_ent, root_ent, rd_a, rd_b;
  kind_t         code;

  logic [FW-1:0] eff;
  logic [KW-1:0] in_key;
  logic [AW-1:0] pos_m1, parent;
  logic [XW-1:0] lft_x, rgt_x, cnt_x;
  logic          l_gt, r_gt;
  logic [KW-1:0] best_key;
  logic          we, ren_a, ren_b;
  logic [AW-1:0] waddr, addr_a, addr_b;
  entry_t        wdata;
  logic          load_out;

  assign in_key = in_data[IN_W-1:IW];
  assign eff = (bound == '0) ? FW'(1) : ((bound > CAP_LIM) ? CAP_LIM : bound);

  assign sts.kind = (count < eff) ? STATUS_APPEND :
                    (((count == '0) || (root_ent.key <= in_key)) ? STATUS_DROP :
                                                                  STATUS_REPLACE);

  assign pos_m1 = pos - AW'(1);
  assign parent = pos_m1 >> 1;
  assign lft_x  = XW'({pos, 1'b1});
  assign rgt_x  = lft_x + XW'(1);
  assign cnt_x  = XW'(count);

  assign l_gt     = lok && (rd_a.key > new_ent.key);
  assign best_key = l_gt ? rd_a.key : new_ent.key;
  assign r_gt     = rok && (rd_b.key > best_key);

  assign sts.pos_zero = (pos == '0);
  assign sts.up_swap  = (rd_a.key <= new_ent.key);
  assign sts.dn_move  = l_gt || r_gt;
  assign sts.out_free = !out_valid || out_ready;

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = new_ent;
    if (cmd.up_rd && sts.pos_zero) begin
      we = 1'b1;
    end else if (cmd.up_cmp) begin
      we    = 1'b1;
      wdata = sts.up_swap ? rd_a : new_ent;
    end else if (cmd.dn_cmp) begin
      we    = 1'b1;
      wdata = r_gt ? rd_b : (l_gt ? rd_a : new_ent);
    end
  end

  assign ren_a  = cmd.up_rd || cmd.dn_rd;
  assign ren_b  = cmd.dn_rd;
  assign addr_a = cmd.up_rd ? parent : lft_x[AW-1:0];
  assign addr_b = rgt_x[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren_a) begin
      rd_a <= mem[addr_a];
    end
    if (ren_b) begin
      rd_b <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == '0)) begin
      root_ent <= wdata;
    end
    if (cmd.accept) begin
      new_ent <= in_data;
      code    <= sts.kind;
      if (sts.kind == STATUS_APPEND) begin
        pos <= count[AW-1:0];
      end else begin
        pos <= '0;
      end
    end
    if (cmd.up_rd) begin
      par <= parent;
    end
    if (cmd.up_cmp && sts.up_swap) begin
      pos <= par;
    end
    if (cmd.dn_rd) begin
      lft <= lft_x[AW-1:0];
      rgt <= rgt_x[AW-1:0];
      lok <= lft_x < cnt_x;
      rok <= rgt_x < cnt_x;
    end
    if (cmd.dn_cmp) begin
      if (r_gt) begin
        pos <= rgt;
      end else if (l_gt) begin
        pos <= lft;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bound <= BOUND_RST;
      count <= '0;
    end else begin
      if (cfg_valid) begin
        bound <= cfg_data;
      end
      if (cmd.accept && (sts.kind == STATUS_APPEND)) begin
        count <= count + FW'(1);
      end
    end
  end

  assign load_out = cmd.emit && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= {{(OUT_W - OUT_BITS){1'b0}},
                   (count == '0),
                   (count == '0) ? IW'(0) : root_ent.id,
                   (count == '0) ? KW'(0) : root_ent.key,
                   count,
                   code};
    end
  end

endmodule

// ===== sv/bounded_max_heap_topk.sv =====
// Bounded max-heap keeping the k smallest priorities seen; one result per push.
// Each push runs to its result before the next is accepted: a drop goes straight to emit;
// an append sifts up toward the root, a replace sifts down from it; emit waits for a free
// output register. Each heap level is a read step and a compare-write step on the
// single-write, dual-read store. A finished result waits in the output register.
// Reset clears the fill count and sets the bound to 256; the store is not cleared.
module bounded_max_heap_topk #(
  parameter int CAPACITY = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bmh_pkg::FW-1:0]     cfg_data,       // bound
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [bmh_pkg::IN_W-1:0]   s_axis_tdata,   // entry_index, entry_priority
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [bmh_pkg::OUT_W-1:0]  m_axis_tdata    // status, fill, root_priority,
                                                     // root_index, heap_empty, pad
);
  import bmh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bmh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bmh_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  logic [1:0] out_status;
  logic       out_empty;

  assign out_status = m_axis_tdata[1:0];
  assign out_empty  = m_axis_tdata[OUT_BITS-1];

  a_one_cmd: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second transfer taken while a push is in progress");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_status == STATUS_APPEND || out_status == STATUS_REPLACE ||
                       out_status == STATUS_DROP))
    else $error("result carries an unknown status");

  a_kept_not_empty: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_status != STATUS_DROP) |-> !out_empty)
    else $error("heap reported empty after keeping an entry");

endmodule
